// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Record layout, command and status codes, slot controls and the prefix-OR
// helper used to turn a set of candidate slots into a shift thermometer.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int OCC_W     = 5;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	typedef enum logic [2:0] {
		CMD_INSERT     = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_POP_BACK   = 3'd4,
		CMD_REMOVE_KEY = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [7:0]  prio;
		logic [7:0]  age;
	} entry_t;

	typedef enum logic [1:0] {
		SLOT_HOLD,
		SLOT_LOAD,
		SLOT_LEFT,
		SLOT_RIGHT
	} slot_op_t;

	// Compare results of one slot against the request in flight
	typedef struct packed {
		logic ge;
		logic gt;
		logic lt;
		logic eq;
	} slot_flags_t;

	// Inclusive prefix OR from slot 0 upward, log-depth
	function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
		logic [DEPTH-1:0] r;
		r = v;
		for (int s = 1; s < DEPTH; s = s * 2) begin
			r = r | (r << s);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/spq_slot.sv -----
// ----------------------------------------------------------------------------
// spq_slot: one storage slot of the queue
// Holds one record, loads a new one or takes a neighbor's, and compares its
// own priority and age against the request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_slot (
	input  wire logic              clk,
	input  wire spq_pkg::slot_op_t op,
	input  wire spq_pkg::entry_t   new_entry,
	input  wire spq_pkg::entry_t   left_entry,
	input  wire spq_pkg::entry_t   right_entry,
	input  wire logic [7:0]        req_prio,
	input  wire logic [7:0]        req_key,
	output spq_pkg::entry_t        entry,
	output spq_pkg::slot_flags_t   flags
);

	spq_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		unique case (op)
			spq_pkg::SLOT_LOAD:  entry_q <= new_entry;
			spq_pkg::SLOT_LEFT:  entry_q <= left_entry;
			spq_pkg::SLOT_RIGHT: entry_q <= right_entry;
			default:             entry_q <= entry_q;
		endcase
	end

	assign entry    = entry_q;
	assign flags.ge = (req_prio >= entry_q.prio);
	assign flags.gt = (req_prio > entry_q.prio);
	assign flags.lt = (req_prio < entry_q.prio);
	assign flags.eq = (req_key == entry_q.age);

endmodule

`default_nettype wire

// ----- src/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded ordered queue of (age, priority, tag) records
// Row of slots that shift toward the back on insert and toward the front on
// removal, with one request in work at a time.
// ----------------------------------------------------------------------------
// Each request is registered on acceptance, then every slot compares
// itself against it in parallel, a prefix-OR over the slot row picks the
// insert or removal point, and the row shifts and the result is written
// when the work stage fires. s_tready stays low while a request sits in
// the work stage, so a new request is taken only once the last one has
// left it. The result register is separate, so a new request is taken
// while a result still waits on m_tready; the work stage only holds when
// the result register is occupied and not being drained. Slots beyond the
// fill count hold stale data and are never reported. Commands 6 and 7
// answer ok with a zero record and leave the queue alone.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [2:0] command, [10:3] entry_age, [18:11] entry_priority,
	// [34:19] entry_tag, [42:35] remove_key, [47:43] zero
	input  wire logic [spq_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [1:0] status, [9:2] out_age, [17:10] out_priority, [33:18] out_tag,
	// [38:34] occupancy, [39] zero
	output logic [spq_pkg::M_TDATA_W-1:0]       m_tdata
);

	localparam int D = spq_pkg::DEPTH;
	localparam int W = spq_pkg::CNT_W;

	// Request register (work stage)
	logic            busy_s1;
	logic [2:0]      cmd_s1;
	spq_pkg::entry_t req_s1;
	logic [7:0]      key_s1;

	// Queue state
	logic [W-1:0]    fill_q;

	// Result register
	logic            m_valid_q;
	spq_pkg::status_t status_q;
	spq_pkg::entry_t out_q;
	logic [spq_pkg::OCC_W-1:0] occ_q;

	spq_pkg::entry_t      slot_entry [D];
	spq_pkg::slot_flags_t slot_flags [D];
	spq_pkg::slot_op_t    slot_op    [D];

	logic [D-1:0] ge_v, gt_v, lt_v, eq_v, occ_v, back_v;
	logic [D-1:0] sel, thermo, lead;
	logic         full, empty, lt_back, eq_back;
	logic         do_ins, do_rem, fire, accept;
	spq_pkg::status_t res_status;
	spq_pkg::entry_t  removed;

	assign s_tready = !busy_s1;
	assign accept   = s_tvalid && s_tready;
	assign fire     = busy_s1 && (!m_valid_q || m_tready);

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (fire) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= s_tdata[2:0];
			req_s1.age   <= s_tdata[10:3];
			req_s1.prio  <= s_tdata[18:11];
			req_s1.tag   <= s_tdata[34:19];
			key_s1       <= s_tdata[42:35];
		end
	end

	// Slot row: each slot sees the new record and both neighbors
	for (genvar i = 0; i < D; i++) begin : g_slot
		spq_pkg::entry_t left_e, right_e;

		if (i == 0) begin : g_first
			assign left_e = req_s1;
		end else begin : g_mid
			assign left_e = slot_entry[i-1];
		end

		if (i == D - 1) begin : g_last
			assign right_e = slot_entry[i];
		end else begin : g_inner
			assign right_e = slot_entry[i+1];
		end

		spq_slot u_slot (
			.clk         (clk),
			.op          (slot_op[i]),
			.new_entry   (req_s1),
			.left_entry  (left_e),
			.right_entry (right_e),
			.req_prio    (req_s1.prio),
			.req_key     (key_s1),
			.entry       (slot_entry[i]),
			.flags       (slot_flags[i])
		);

		assign ge_v[i]   = slot_flags[i].ge;
		assign gt_v[i]   = slot_flags[i].gt;
		assign lt_v[i]   = slot_flags[i].lt;
		assign eq_v[i]   = slot_flags[i].eq;
		assign occ_v[i]  = (W'(i) < fill_q);
		assign back_v[i] = (fill_q == W'(i + 1));
	end

	assign full    = (fill_q == W'(D));
	assign empty   = (fill_q == '0);
	assign lt_back = |(lt_v & back_v);
	assign eq_back = |(eq_v & back_v);

	// Pick candidate slots for the request
	always_comb begin
		sel        = '0;
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		res_status = spq_pkg::ST_OK;
		unique case (cmd_s1)
			spq_pkg::CMD_INSERT: begin
				if (full) begin
					res_status = spq_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					if (empty || gt_v[0]) begin
						sel = '1;
					end else if (lt_back) begin
						sel = '0;
					end else begin
						// first slot after the head whose priority is not above it
						sel = ge_v & occ_v & ~D'(1);
					end
				end
			end
			spq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					res_status = spq_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					sel    = '1;
				end
			end
			spq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					res_status = spq_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			spq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					res_status = spq_pkg::ST_EMPTY;
				end else begin
					do_rem = 1'b1;
					sel    = D'(1);
				end
			end
			spq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					res_status = spq_pkg::ST_EMPTY;
				end else begin
					do_rem = 1'b1;
					sel    = back_v;
				end
			end
			spq_pkg::CMD_REMOVE_KEY: begin
				if (empty) begin
					res_status = spq_pkg::ST_EMPTY;
				end else begin
					// head first, then tail, then first match from the second slot
					if (eq_v[0]) begin
						sel = D'(1);
					end else if (eq_back) begin
						sel = back_v;
					end else begin
						sel = eq_v & occ_v & ~D'(1);
					end
					if (sel == '0) begin
						res_status = spq_pkg::ST_NOT_FOUND;
					end else begin
						do_rem = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Insert point falls on the back when no candidate is found
	assign thermo = do_ins ? spq_pkg::prefix_or(sel | ~occ_v) : spq_pkg::prefix_or(sel);
	assign lead   = thermo & ~(thermo << 1);

	// Drive slot controls and gather the removed record
	always_comb begin
		removed = '0;
		for (int i = 0; i < D; i++) begin
			slot_op[i] = spq_pkg::SLOT_HOLD;
			if (fire && do_ins) begin
				if (lead[i]) begin
					slot_op[i] = spq_pkg::SLOT_LOAD;
				end else if (thermo[i]) begin
					slot_op[i] = spq_pkg::SLOT_LEFT;
				end
			end else if (fire && do_rem && thermo[i]) begin
				slot_op[i] = spq_pkg::SLOT_RIGHT;
			end
			if (do_rem && lead[i]) begin
				removed = removed | slot_entry[i];
			end
		end
	end

	// Advance fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (fire && do_ins) begin
			fill_q <= fill_q + W'(1);
		end else if (fire && do_rem) begin
			fill_q <= fill_q - W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= res_status;
			out_q    <= removed;
			if (do_ins) begin
				occ_q <= spq_pkg::OCC_W'(fill_q + W'(1));
			end else if (do_rem) begin
				occ_q <= spq_pkg::OCC_W'(fill_q - W'(1));
			end else begin
				occ_q <= spq_pkg::OCC_W'(fill_q);
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, occ_q, out_q.tag, out_q.prio, out_q.age, status_q};

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= W'(D))
		else $error("fill count beyond depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_ins |=> fill_q == $past(fill_q) + W'(1))
		else $error("insert did not grow the queue");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_rem |=> fill_q == $past(fill_q) - W'(1))
		else $error("removal did not shrink the queue");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_status == spq_pkg::ST_FULL |-> full)
		else $error("full reported on a queue with room");

	a_rem_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_rem |-> $onehot(lead & occ_v))
		else $error("removal point not a single held slot");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_valid_q && !busy_s1)
		else $error("finished request left no result");

endmodule

`default_nettype wire

// ----- dv/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: scoreboard for the sorted priority queue
// Watches the request and result channels. Keeps its own copy of the slot row,
// predicts the result of every request it sees accepted, and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module spq_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
	output int                                 errors,
	output int                                 pending
);
	import spq_pkg::*;

	// Same bit order as m_tdata[38:0]: status lowest, occupancy highest
	typedef struct packed {
		logic [OCC_W-1:0] occ;
		entry_t           rec;
		status_t          status;
	} result_t;

	entry_t  row [DEPTH];
	int      held;
	result_t expected_results [$];
	result_t got;
	result_t want;
	result_t predicted;
	entry_t  req_rec;

	task automatic report(input string what, input logic [39:0] got_v,
			input logic [39:0] want_v);
		errors++;
		$display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got_v, want_v);
	endtask

	task automatic open_at(input int pos, input entry_t e);
		for (int i = held; i > pos; i--)
			row[i] = row[i-1];
		row[pos] = e;
		held++;
	endtask

	task automatic close_at(input int pos, output entry_t e);
		e = row[pos];
		for (int i = pos; i + 1 < held; i++)
			row[i] = row[i+1];
		held--;
	endtask

	// Slot that a priority insert lands in
	function automatic int rank_slot(input logic [7:0] p);
		if (held == 0 || p > row[0].prio)
			return 0;
		if (p < row[held-1].prio)
			return held;
		for (int i = 1; i < held; i++)
			if (p >= row[i].prio)
				return i;
		return held;
	endfunction

	task automatic advance_queue(input logic [2:0] cmd, input entry_t rec,
			input logic [7:0] key, output result_t r);
		int hit;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		case (cmd)
			CMD_INSERT, CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (held >= DEPTH)
					r.status = ST_FULL;
				else if (cmd == CMD_INSERT)
					open_at(rank_slot(rec.prio), rec);
				else if (cmd == CMD_PUSH_FRONT)
					open_at(0, rec);
				else
					open_at(held, rec);
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_KEY: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// key search: front, then back, then from the second slot on
					if (cmd == CMD_POP_FRONT)
						hit = 0;
					else if (cmd == CMD_POP_BACK)
						hit = held - 1;
					else if (row[0].age == key)
						hit = 0;
					else if (row[held-1].age == key)
						hit = held - 1;
					else
						for (int i = 1; i < held; i++)
							if (row[i].age == key) begin
								hit = i;
								break;
							end
					if (hit < 0)
						r.status = ST_NOT_FOUND;
					else
						close_at(hit, r.rec);
				end
			end
			default: ;
		endcase
		r.occ = OCC_W'(held);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			expected_results.delete();
			pending = 0;
			errors = 0;
		end else begin
			// results first: a request taken on this edge cannot answer on it
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[M_TDATA_W-2:0]);
				if (expected_results.size() == 0) begin
					report("result with nothing outstanding", m_tdata, '0);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status)
						report("status", 40'(got.status), 40'(want.status));
					if (got.rec.age !== want.rec.age)
						report("out_age", 40'(got.rec.age), 40'(want.rec.age));
					if (got.rec.prio !== want.rec.prio)
						report("out_priority", 40'(got.rec.prio), 40'(want.rec.prio));
					if (got.rec.tag !== want.rec.tag)
						report("out_tag", 40'(got.rec.tag), 40'(want.rec.tag));
					if (got.occ !== want.occ)
						report("occupancy", 40'(got.occ), 40'(want.occ));
				end
			end
			if (s_tvalid && s_tready) begin
				req_rec.age  = s_tdata[10:3];
				req_rec.prio = s_tdata[18:11];
				req_rec.tag  = s_tdata[34:19];
				advance_queue(s_tdata[2:0], req_rec, s_tdata[42:35], predicted);
				expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- dv/tb_sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: stimulus and verdict for the sorted priority queue
// A directed sweep of every command and corner case, then random requests in
// phases that fill, drain or churn the queue, with random gaps on both sides,
// two long result stalls and four full drain pauses. The checker scores every result.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int RANDOM_REQUESTS = 1650;
	localparam int PHASE_LEN       = 40;
	localparam int MAX_GAP         = 18;
	localparam int LONG_HOLD       = 120;
	localparam int IDLE_LIMIT      = 1000;
	localparam int DRAIN_CYCLES    = 10;

	// Phase kinds of the random part
	localparam int FILLING  = 0;
	localparam int DRAINING = 1;
	localparam int MIXED    = 2;

	// Codes the block must answer with ok and a zero record
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Handshakes seen at the last rising edge, read back at the falling edge
	logic req_taken = 1'b0;
	logic res_taken = 1'b0;
	int   idle_cycles = 0;
	int   errors;
	int   pending;

	always #1 clk = ~clk;

	sorted_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	spq_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// Record handshakes and watch for a hung block: any edge with neither a
	// request nor a result accepted counts toward the limit.
	always @(posedge clk) begin
		req_taken <= s_tvalid && s_tready;
		res_taken <= m_tvalid && m_tready;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("FAIL sorted_priority_queue");
			$finish;
		end
	end

	// Offer one request after idling for the given gap; called and returns at a
	// falling edge. With no gap, valid simply stays high for the next request.
	task automatic send_request(input logic [2:0] cmd, input logic [7:0] age,
			input logic [7:0] prio, input logic [15:0] tag, input logic [7:0] key,
			input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, key, tag, prio, age, cmd};
		do @(negedge clk); while (!req_taken);
	endtask

	// Mostly a few small values so that keys hit, now and then the full range
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 7));
	endfunction

	// Cluster priorities on the extremes half the time to force ties
	function automatic logic [7:0] pick_priority();
		logic [1:0] r;
		r = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 255));
		return (r[1] ? 8'hFE : 8'h00) | {7'd0, r[0]};
	endfunction

	function automatic logic [2:0] pick_command(input int phase);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return CMD_SPARE_6;
		if (r < 4)
			return CMD_SPARE_7;
		case (phase)
			FILLING: begin
				if (r < 50) return CMD_INSERT;
				if (r < 65) return CMD_PUSH_FRONT;
				if (r < 80) return CMD_PUSH_BACK;
				if (r < 87) return CMD_POP_FRONT;
				if (r < 93) return CMD_POP_BACK;
				return CMD_REMOVE_KEY;
			end
			DRAINING: begin
				if (r < 18) return CMD_INSERT;
				if (r < 23) return CMD_PUSH_FRONT;
				if (r < 28) return CMD_PUSH_BACK;
				if (r < 50) return CMD_POP_FRONT;
				if (r < 70) return CMD_POP_BACK;
				return CMD_REMOVE_KEY;
			end
			default: begin
				if (r < 34) return CMD_INSERT;
				if (r < 42) return CMD_PUSH_FRONT;
				if (r < 50) return CMD_PUSH_BACK;
				if (r < 62) return CMD_POP_FRONT;
				if (r < 74) return CMD_POP_BACK;
				return CMD_REMOVE_KEY;
			end
		endcase
	endfunction

	// Result side: random stall per result, calm stretches now and then, and
	// two long hold-offs so that the block backs up and stalls its input.
	initial begin
		int  got_results;
		int  hold;
		bit  calm;
		got_results = 0;
		calm = 1'b0;
		@(negedge clk);
		forever begin
			if (got_results % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (got_results == 120 || got_results == 1100)
				hold = LONG_HOLD;
			else
				hold = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!res_taken);
			got_results++;
		end
	end

	// Request side and verdict
	initial begin
		int         phase;
		bit         calm;
		logic [2:0] cmd;
		phase = MIXED;
		calm  = 1'b0;

		// hold reset, then release it away from the rising edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty queue, spare codes, lone-entry cases, each insert
		// position, pushes, every remove path, then pops.
		send_request(CMD_POP_FRONT,  8'h00, 8'h00, 16'h0000, 8'h00, 0);
		send_request(CMD_POP_BACK,   8'h00, 8'h00, 16'h0000, 8'h00, 1);
		send_request(CMD_REMOVE_KEY, 8'h00, 8'h00, 16'h0000, 8'hFF, 0);
		send_request(CMD_SPARE_6,    8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 2);
		send_request(CMD_SPARE_7,    8'hAA, 8'h55, 16'hA5A5, 8'h5A, 0);
		// insert into an empty queue, then pop the back of one entry
		send_request(CMD_INSERT,     8'h00, 8'h00, 16'h0000, 8'h00, 0);
		send_request(CMD_POP_BACK,   8'h00, 8'h00, 16'h0000, 8'h00, 3);
		send_request(CMD_INSERT,     8'h10, 8'h80, 16'h0001, 8'h00, 0);
		// tie with the lone head appends behind it
		send_request(CMD_INSERT,     8'h11, 8'h80, 16'h0002, 8'h00, 0);
		// outranks head, below tail, then lands mid-row on a tie
		send_request(CMD_INSERT,     8'hFF, 8'hFF, 16'hFFFF, 8'h00, 1);
		send_request(CMD_INSERT,     8'h12, 8'h00, 16'h0003, 8'h00, 0);
		send_request(CMD_INSERT,     8'h13, 8'h80, 16'h0004, 8'h00, 0);
		send_request(CMD_PUSH_FRONT, 8'h14, 8'h05, 16'h0005, 8'h00, 4);
		send_request(CMD_PUSH_BACK,  8'h15, 8'hC8, 16'h0006, 8'h00, 0);
		// remove: front match, back match, middle match, no match
		send_request(CMD_REMOVE_KEY, 8'h00, 8'h00, 16'h0000, 8'h14, 0);
		send_request(CMD_REMOVE_KEY, 8'h00, 8'h00, 16'h0000, 8'h15, 2);
		send_request(CMD_REMOVE_KEY, 8'h00, 8'h00, 16'h0000, 8'h10, 0);
		send_request(CMD_REMOVE_KEY, 8'h00, 8'h00, 16'h0000, 8'h4D, 0);
		send_request(CMD_POP_FRONT,  8'h00, 8'h00, 16'h0000, 8'h00, 0);
		send_request(CMD_POP_BACK,   8'h00, 8'h00, 16'h0000, 8'h00, 5);

		// Random part in phases; each phase picks its command mix and whether
		// the sender idles at all.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % PHASE_LEN == 0) begin
				phase = $urandom_range(FILLING, MIXED);
				calm  = ($urandom_range(0, 3) == 0);
			end
			// pause until every outstanding result has come back
			if (n % 400 == 200) begin
				s_tvalid <= 1'b0;
				do @(negedge clk); while (pending != 0);
			end
			cmd = pick_command(phase);
			send_request(cmd, pick_byte(), pick_priority(), 16'($urandom), pick_byte(),
				calm ? 0 : $urandom_range(0, MAX_GAP));
		end

		// Drain: stop offering, wait out every result, then a short settle
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("PASS sorted_priority_queue");
		else
			$display("FAIL sorted_priority_queue");
		$finish;
	end

endmodule

// ----- files.f -----
src/spq_pkg.sv
src/spq_slot.sv
src/sorted_priority_queue.sv
dv/spq_checker.sv
dv/tb_sorted_priority_queue.sv
